[rtl/core/cia_pkg.sv]
// Package for the complex integer ALU: widths, opcodes and the word
// carried along the divider cell chain. No dependencies.
`default_nettype none
package cia_pkg;
	localparam int PART_WIDTH = 16;
	localparam int NUM_WIDTH  = 2 * PART_WIDTH;
	localparam int RES_WIDTH  = 33;
	localparam int DIV_CELLS  = NUM_WIDTH;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_NE  = 3'd5
	} op_t;

	typedef struct packed {
		logic                        is_div;
		logic                        dz;
		logic                        cmp;
		logic signed [RES_WIDTH-1:0] fix_re;
		logic signed [RES_WIDTH-1:0] fix_im;
		logic [NUM_WIDTH-1:0]        den;
		logic                        neg_re;
		logic                        neg_im;
		logic [NUM_WIDTH-1:0]        rem_re;
		logic [NUM_WIDTH-1:0]        num_re;
		logic [NUM_WIDTH-1:0]        rem_im;
		logic [NUM_WIDTH-1:0]        num_im;
	} cell_t;
endpackage
`default_nettype wire

[rtl/core/cia_front.sv]
// Front end of the complex integer ALU: input register, multiplier stage
// and sum stage that loads the first divider cell. Uses cia_pkg.
`default_nettype none
module cia_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [2:0]                          opcode,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_im,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_im,
	output logic                                     vld_o,
	output cia_pkg::cell_t                           cell_o
);
	localparam int PW = cia_pkg::PART_WIDTH;
	localparam int NW = cia_pkg::NUM_WIDTH;
	localparam int RW = cia_pkg::RES_WIDTH;

	logic                 vld_s1, vld_s2, vld_s3;
	logic [2:0]           op_s1, op_s2;
	logic signed [PW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [NW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, sq_r_s2, sq_i_s2;
	logic signed [PW:0]   sum_re_s2, sum_im_s2, dif_re_s2, dif_im_s2;
	logic                 eq_s2, bz_s2;
	cia_pkg::cell_t       cell_s3, cell_d;
	logic signed [NW:0]   n_re, n_im;
	logic signed [RW-1:0] m_re, m_im;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: capture operands
	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		ar_s1 <= a_re;
		ai_s1 <= a_im;
		br_s1 <= b_re;
		bi_s1 <= b_im;
	end

	// stage 2: all products, narrow sums and tests
	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		p_rr_s2   <= ar_s1 * br_s1;
		p_ii_s2   <= ai_s1 * bi_s1;
		p_ri_s2   <= ar_s1 * bi_s1;
		p_ir_s2   <= ai_s1 * br_s1;
		sq_r_s2   <= br_s1 * br_s1;
		sq_i_s2   <= bi_s1 * bi_s1;
		sum_re_s2 <= {ar_s1[PW-1], ar_s1} + {br_s1[PW-1], br_s1};
		sum_im_s2 <= {ai_s1[PW-1], ai_s1} + {bi_s1[PW-1], bi_s1};
		dif_re_s2 <= {ar_s1[PW-1], ar_s1} - {br_s1[PW-1], br_s1};
		dif_im_s2 <= {ai_s1[PW-1], ai_s1} - {bi_s1[PW-1], bi_s1};
		eq_s2     <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		bz_s2     <= (br_s1 == '0) && (bi_s1 == '0);
	end

	// stage 3: fold products into results and divider numerators
	always_comb begin
		n_re = {p_rr_s2[NW-1], p_rr_s2} + {p_ii_s2[NW-1], p_ii_s2};
		n_im = {p_ir_s2[NW-1], p_ir_s2} - {p_ri_s2[NW-1], p_ri_s2};
		m_re = RW'({p_rr_s2[NW-1], p_rr_s2} - {p_ii_s2[NW-1], p_ii_s2});
		m_im = RW'({p_ri_s2[NW-1], p_ri_s2} + {p_ir_s2[NW-1], p_ir_s2});
		cell_d        = '0;
		cell_d.den    = NW'($unsigned(sq_r_s2)) + NW'($unsigned(sq_i_s2));
		cell_d.neg_re = n_re[NW];
		cell_d.neg_im = n_im[NW];
		cell_d.num_re = n_re[NW] ? NW'(-n_re) : NW'(n_re);
		cell_d.num_im = n_im[NW] ? NW'(-n_im) : NW'(n_im);
		case (op_s2)
			cia_pkg::OP_ADD: begin
				cell_d.fix_re = RW'(sum_re_s2);
				cell_d.fix_im = RW'(sum_im_s2);
			end
			cia_pkg::OP_SUB: begin
				cell_d.fix_re = RW'(dif_re_s2);
				cell_d.fix_im = RW'(dif_im_s2);
			end
			cia_pkg::OP_MUL: begin
				cell_d.fix_re = m_re;
				cell_d.fix_im = m_im;
			end
			cia_pkg::OP_DIV: begin
				cell_d.is_div = !bz_s2;
				cell_d.dz     = bz_s2;
			end
			cia_pkg::OP_EQ:  cell_d.cmp = eq_s2;
			cia_pkg::OP_NE:  cell_d.cmp = !eq_s2;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		cell_s3 <= cell_d;
	end

	assign vld_o  = vld_s3;
	assign cell_o = cell_s3;
endmodule
`default_nettype wire

[rtl/core/cia_div_cell.sv]
// One cell of the divider chain: retires one quotient bit for the real and
// the imaginary part and hands the word to the next cell. Uses cia_pkg.
`default_nettype none
module cia_div_cell (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   vld_i,
	input  cia_pkg::cell_t cell_i,
	output logic        vld_o,
	output cia_pkg::cell_t cell_o
);
	localparam int NW = cia_pkg::NUM_WIDTH;

	logic [NW:0]    trial_re, trial_im;
	logic           ge_re, ge_im;
	cia_pkg::cell_t cell_d, cell_q;
	logic           vld_q;

	always_comb begin
		trial_re = {cell_i.rem_re, cell_i.num_re[NW-1]};
		trial_im = {cell_i.rem_im, cell_i.num_im[NW-1]};
		ge_re    = trial_re >= {1'b0, cell_i.den};
		ge_im    = trial_im >= {1'b0, cell_i.den};
		cell_d        = cell_i;
		cell_d.rem_re = ge_re ? NW'(trial_re - {1'b0, cell_i.den}) : NW'(trial_re);
		cell_d.rem_im = ge_im ? NW'(trial_im - {1'b0, cell_i.den}) : NW'(trial_im);
		cell_d.num_re = {cell_i.num_re[NW-2:0], ge_re};
		cell_d.num_im = {cell_i.num_im[NW-2:0], ge_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	assign vld_o  = vld_q;
	assign cell_o = cell_q;
endmodule
`default_nettype wire

[rtl/core/complex_integer_alu.sv]
// Top level of the complex integer ALU: front end, divider cell chain and
// result register. Uses cia_pkg, cia_front and cia_div_cell.
//
// Usage:
//   Drive opcode and the four operand parts and raise start; a word is
//   taken at every rising edge with start high and busy low. busy is
//   always low here, so a new word may enter every cycle.
//   Opcodes: add, subtract, multiply, divide, equal, not equal; unused
//   codes give an all-zero result.
//   Every opcode walks the same fixed path, so results leave in order:
//   input register, multiplier stage, sum stage, one divider cell per
//   quotient bit (2*PART_WIDTH cells), output register. A word shows on
//   res_re/res_im/cmp_true/div_by_zero with done high once it leaves the
//   output register.
//   Throughput is one word per cycle, set by the one-bit-per-cell divider
//   chain; each cell does one compare and subtract per part.
//   Quotients are truncated toward zero; a zero divisor gives 0+0i with
//   div_by_zero set.
//   Each result stands for exactly one cycle; the receiver cannot stall,
//   so it must take it then.
//   Reset clears all valid flags: no word is in flight afterwards.
`default_nettype none
module complex_integer_alu (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [2:0]                            opcode,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_im,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_im,
	output logic                                       done,
	output logic signed [cia_pkg::RES_WIDTH-1:0]       res_re,
	output logic signed [cia_pkg::RES_WIDTH-1:0]       res_im,
	output logic                                       cmp_true,
	output logic                                       div_by_zero
);
	localparam int NC = cia_pkg::DIV_CELLS;
	localparam int RW = cia_pkg::RES_WIDTH;

	logic           vld_chain [0:NC];
	cia_pkg::cell_t cell_chain [0:NC];
	cia_pkg::cell_t last;
	logic [RW-1:0]  q_re, q_im;
	logic           done_q, cmp_q, dz_q;
	logic signed [RW-1:0] re_q, im_q;

	// the pipeline never holds a word back
	assign busy = 1'b0;

	cia_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.vld_o  (vld_chain[0]),
		.cell_o (cell_chain[0])
	);

	// one cell per quotient bit, most significant first
	for (genvar i = 0; i < NC; i++) begin : g_cell
		cia_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_chain[i]),
			.cell_i (cell_chain[i]),
			.vld_o  (vld_chain[i+1]),
			.cell_o (cell_chain[i+1])
		);
	end

	// restore the sign of the quotient magnitudes
	always_comb begin
		last = cell_chain[NC];
		q_re = last.neg_re ? RW'(-{1'b0, last.num_re}) : RW'({1'b0, last.num_re});
		q_im = last.neg_im ? RW'(-{1'b0, last.num_im}) : RW'({1'b0, last.num_im});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_chain[NC];
		end
	end

	// result register: divide takes the chain output, the rest pass through
	always_ff @(posedge clk) begin
		re_q  <= last.is_div ? q_re : last.fix_re;
		im_q  <= last.is_div ? q_im : last.fix_im;
		cmp_q <= last.cmp;
		dz_q  <= last.dz;
	end

	assign done        = done_q;
	assign res_re      = re_q;
	assign res_im      = im_q;
	assign cmp_true    = cmp_q;
	assign div_by_zero = dz_q;
endmodule
`default_nettype wire

[rtl/core/cia_checker.sv]
// Port checker for the complex integer ALU and its bind to the top level.
// Depends on complex_integer_alu port names only.
`default_nettype none
module cia_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [32:0] res_re,
	input wire logic [32:0] res_im,
	input wire logic        cmp_true,
	input wire logic        div_by_zero
);
	// a result only follows a start issued a fixed latency earlier
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 36))
		else $error("result without matching start");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> (res_re == '0 && res_im == '0 && !cmp_true))
		else $error("divide by zero with nonzero result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmp_true) |-> (res_re == '0 && res_im == '0))
		else $error("compare with nonzero result");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
endmodule

bind complex_integer_alu cia_port_checker u_cia_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.res_re      (res_re),
	.res_im      (res_im),
	.cmp_true    (cmp_true),
	.div_by_zero (div_by_zero)
);
`default_nettype wire

[sim/cia_checker.sv]
`timescale 1ns / 100ps
// Result checker for the complex integer ALU: computes the expected result of
// every word taken in and compares it with each done word. Uses cia_pkg.
module cia_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  busy,
	input  wire logic [2:0]                            opcode,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] a_im,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_re,
	input  wire logic signed [cia_pkg::PART_WIDTH-1:0] b_im,
	input  wire logic                                  done,
	input  wire logic signed [cia_pkg::RES_WIDTH-1:0]  res_re,
	input  wire logic signed [cia_pkg::RES_WIDTH-1:0]  res_im,
	input  wire logic                                  cmp_true,
	input  wire logic                                  div_by_zero,
	output int                                         fail_count,
	output int                                         pending
);
	import cia_pkg::*;

	typedef struct packed {
		logic [RES_WIDTH-1:0] re;
		logic [RES_WIDTH-1:0] im;
		logic                 cmp;
		logic                 dz;
	} alu_res_t;

	alu_res_t expected_q[$];

	function automatic longint quot_trunc(longint num, longint den);
		longint q;
		q = (num < 0 ? -num : num) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic alu_res_t complex_result(logic [2:0] op, longint ar, longint ai,
			longint br, longint bi);
		alu_res_t r;
		longint   re, im, den;
		re = 0;
		im = 0;
		r = '0;
		case (op)
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = ar * br - ai * bi;
				im = ar * bi + ai * br;
			end
			OP_DIV: begin
				if (br == 0 && bi == 0) begin
					r.dz = 1'b1;
				end else begin
					den = br * br + bi * bi;
					re = quot_trunc(ar * br + ai * bi, den);
					im = quot_trunc(ai * br - ar * bi, den);
				end
			end
			OP_EQ: r.cmp = (ar == br && ai == bi);
			OP_NE: r.cmp = (ar != br || ai != bi);
			default: ;
		endcase
		r.re = re[RES_WIDTH-1:0];
		r.im = im[RES_WIDTH-1:0];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		alu_res_t want;
		if (!arst_n) begin
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (start && !busy)
				expected_q.push_back(complex_result(opcode, a_re, a_im, b_re, b_im));
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result re=%0d im=%0d", $time, res_re, res_im);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want.re !== res_re || want.im !== res_im || want.cmp !== cmp_true
							|| want.dz !== div_by_zero) begin
						$display("%0t: expected re=%0d im=%0d cmp=%b dz=%b, got re=%0d im=%0d cmp=%b dz=%b",
							$time, $signed(want.re), $signed(want.im), want.cmp, want.dz,
							res_re, res_im, cmp_true, div_by_zero);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Regression top for the complex integer ALU: clock, reset, stimulus and the
// verdict. Uses cia_pkg, complex_integer_alu and cia_checker.
module tb;
	import cia_pkg::*;

	localparam int RANDOM_WORDS = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 200000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [2:0]                   opcode = '0;
	logic signed [PART_WIDTH-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic                         busy, done, cmp_true, div_by_zero;
	logic signed [RES_WIDTH-1:0]  res_re, res_im;
	int                           fail_count, pending;
	int                           idle_pct;
	longint                       cycles = 0;

	always #5 clk = ~clk;

	complex_integer_alu dut (.*);

	cia_checker checker_i (.*);

	// Watchdog: a hung handshake or lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("complex_integer_alu regression: fail");
			$finish;
		end
	end

	// Pick a part value, weighted toward the corners and small magnitudes.
	function automatic logic [PART_WIDTH-1:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3: return 16'hffff;
			4, 5: return PART_WIDTH'($urandom_range(0, 15) - 8);
			default: return PART_WIDTH'($urandom());
		endcase
	endfunction

	// Idle at random with start low, then present one word and hold it until taken.
	task automatic send_word(logic [2:0] op, logic [PART_WIDTH-1:0] ar,
			logic [PART_WIDTH-1:0] ai, logic [PART_WIDTH-1:0] br,
			logic [PART_WIDTH-1:0] bi);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		logic [2:0] op;
		logic [PART_WIDTH-1:0] pr, pi;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: every opcode, extreme parts, zero divisor, unused codes.
		for (int k = 0; k < 8; k++) begin
			send_word(k[2:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_word(k[2:0], 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		end
		send_word(OP_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		send_word(OP_DIV, 16'h0005, 16'hfffb, 16'h0000, 16'h0001);
		send_word(OP_DIV, 16'hfff9, 16'h0003, 16'h0002, 16'h0000);
		send_word(OP_EQ, 16'h1234, 16'h5678, 16'h1234, 16'h5679);
		send_word(OP_NE, 16'h1234, 16'h5678, 16'h1235, 16'h5678);
		send_word(OP_NE, 16'h1234, 16'h5678, 16'h1234, 16'h5678);

		// Random phases: sender idles 27%, then 63%, then never.
		for (int w = 0; w < RANDOM_WORDS; w++) begin
			idle_pct = (w < RANDOM_WORDS / 3) ? 27 : (w < 2 * RANDOM_WORDS / 3) ? 63 : 0;
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(OP_ADD, OP_NE));
			pr = pick_part();
			pi = pick_part();
			// Equal operands make the compare opcodes interesting.
			if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1))
				send_word(op, pr, pi, pr, ($urandom_range(0, 1)) ? pi : pick_part());
			else
				send_word(op, pr, pi, pick_part(), pick_part());
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("complex_integer_alu regression: pass");
		else
			$display("complex_integer_alu regression: fail");
		$finish;
	end
endmodule

[filelist.f]
rtl/core/cia_pkg.sv
rtl/core/cia_front.sv
rtl/core/cia_div_cell.sv
rtl/core/complex_integer_alu.sv
rtl/core/cia_checker.sv
sim/cia_checker.sv
sim/tb.sv
